// ===== rtl/udp_pbd_pkg.sv =====
package udp_pbd_pkg;
	localparam int unsigned SLOTS_DEF = 16;
	localparam logic [15:0] EPH_LOW_RST = 16'd49152;
	localparam logic [15:0] EPH_HIGH_RST = 16'd65535;
	localparam logic [15:0] EPH_FIRST_RST = 16'd49152;

	localparam logic [1:0] OP_BIND = 2'd0;
	localparam logic [1:0] OP_UNBIND = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ADDR_NA = 2'd1;
	localparam logic [1:0] ST_BOUND = 2'd2;
	localparam logic [1:0] ST_IN_USE = 2'd3;

	localparam logic [1:0] REG_LOW = 2'd0;
	localparam logic [1:0] REG_HIGH = 2'd1;
	localparam logic [1:0] REG_FIRST = 2'd2;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic cand_load;
		logic cand_adv;
		logic commit;
		logic unbind;
		logic done;
		logic [1:0] status;
		logic use_cand;
		logic found;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic slot_out;
		logic slot_bound;
		logic addr_na;
		logic port_zero;
		logic scan_last;
		logic hit;
		logic cand_zero;
		logic tries_last;
	} sts_t;
endpackage

// ===== rtl/udp_port_bind_and_demux_table.sv =====
// A refused bind, an unbind or an unknown op gives its result from the decide state, without a scan.
// A lookup or an explicit bind scans every slot through the single read port of the slot
// memory before it gives its result.
// An ephemeral bind scans every slot once for each candidate port that it tries in turn;
// busy drops with done, so the next beat is taken at the edge ending it.
// The receiver cannot stall. Reset clears all bindings and loads the ephemeral defaults.
module udp_port_bind_and_demux_table #(
	parameter int unsigned SLOTS = udp_pbd_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] op,
	input logic [3:0] slot,
	input logic family,
	input logic [63:0] addr_a_hi,
	input logic [63:0] addr_a_lo,
	input logic [15:0] port_a,
	input logic [63:0] addr_b_hi,
	input logic [63:0] addr_b_lo,
	input logic [15:0] port_b,
	input logic addr_owned,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic done,
	output logic [1:0] status,
	output logic found,
	output logic [3:0] match_slot,
	output logic [15:0] port
);
	import udp_pbd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	udp_pbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	udp_pbd_dp #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .slot(slot),
		.family(family), .addr_a_hi(addr_a_hi), .addr_a_lo(addr_a_lo), .port_a(port_a),
		.addr_b_hi(addr_b_hi), .addr_b_lo(addr_b_lo), .port_b(port_b),
		.addr_owned(addr_owned), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .sts(sts), .res_valid(done), .status(status),
		.found(found), .match_slot(match_slot), .port(port)
	);
endmodule

// ===== rtl/udp_pbd_ram.sv =====
module udp_pbd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/udp_pbd_ctrl.sv =====
module udp_pbd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input udp_pbd_pkg::sts_t sts,
	output udp_pbd_pkg::cmd_t cmd
);
	import udp_pbd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_SCAN, S_EPH_START, S_EPH_SCAN, S_EPH_NEXT
	} state_t;

	state_t state_q;
	logic busy_q;

	assign busy = busy_q || cmd.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			cmd <= '0;
		end else begin
			cmd <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						cmd.load <= 1'b1;
						busy_q <= 1'b1;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (sts.op == OP_BIND) begin
						if (sts.slot_out || sts.addr_na) begin
							cmd.status <= ST_ADDR_NA;
							cmd.done <= 1'b1;
							state_q <= S_IDLE;
							busy_q <= 1'b0;
						end else if (sts.slot_bound) begin
							cmd.status <= ST_BOUND;
							cmd.done <= 1'b1;
							state_q <= S_IDLE;
							busy_q <= 1'b0;
						end else if (sts.port_zero) begin
							cmd.cand_load <= 1'b1;
							state_q <= S_EPH_START;
						end else begin
							cmd.scan_clr <= 1'b1;
							state_q <= S_SCAN;
						end
					end else if (sts.op == OP_LOOKUP) begin
						cmd.scan_clr <= 1'b1;
						state_q <= S_SCAN;
					end else begin
						cmd.unbind <= (sts.op == OP_UNBIND) && !sts.slot_out;
						cmd.done <= 1'b1;
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end
				end
				S_SCAN: begin
					cmd.scan_step <= 1'b1;
					if (sts.scan_last) begin
						cmd.scan_step <= 1'b0;
						cmd.done <= 1'b1;
						state_q <= S_IDLE;
						busy_q <= 1'b0;
						if (sts.op == OP_BIND) begin
							cmd.status <= sts.hit ? ST_IN_USE : ST_OK;
							cmd.commit <= !sts.hit;
						end else begin
							cmd.found <= 1'b1;
						end
					end
				end
				S_EPH_START: begin
					cmd.cand_adv <= 1'b1;
					cmd.scan_clr <= 1'b1;
					state_q <= S_EPH_SCAN;
				end
				S_EPH_SCAN: begin
					cmd.scan_step <= 1'b1;
					if (sts.scan_last) begin
						cmd.scan_step <= 1'b0;
						if (!sts.hit && !sts.cand_zero) begin
							cmd.status <= ST_OK;
							cmd.use_cand <= 1'b1;
							cmd.commit <= 1'b1;
							cmd.done <= 1'b1;
							state_q <= S_IDLE;
							busy_q <= 1'b0;
						end else if (sts.tries_last) begin
							cmd.status <= ST_IN_USE;
							cmd.done <= 1'b1;
							state_q <= S_IDLE;
							busy_q <= 1'b0;
						end else begin
							state_q <= S_EPH_NEXT;
						end
					end
				end
				S_EPH_NEXT: begin
					cmd.cand_load <= 1'b1;
					state_q <= S_EPH_START;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end
endmodule

// ===== rtl/udp_pbd_dp.sv =====
module udp_pbd_dp #(
	parameter int unsigned SLOTS = udp_pbd_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] op,
	input logic [3:0] slot,
	input logic family,
	input logic [63:0] addr_a_hi,
	input logic [63:0] addr_a_lo,
	input logic [15:0] port_a,
	input logic [63:0] addr_b_hi,
	input logic [63:0] addr_b_lo,
	input logic [15:0] port_b,
	input logic addr_owned,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input udp_pbd_pkg::cmd_t cmd,
	output udp_pbd_pkg::sts_t sts,
	output logic res_valid,
	output logic [1:0] status,
	output logic found,
	output logic [3:0] match_slot,
	output logic [15:0] port
);
	import udp_pbd_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS > 1 ? SLOTS : 2);
	localparam int unsigned RW = 1 + 16 + 128 + 16 + 128;

	logic [1:0] op_q;
	logic [3:0] slot_q;
	logic fam_q, owned_q;
	logic [63:0] ahi_q, alo_q, bhi_q, blo_q;
	logic [15:0] pa_q, pb_q;
	logic [15:0] low_q, high_q, next_q, cand_q;
	logic [16:0] tries_q;
	logic [SLOTS-1:0] valid_q;
	logic [AW:0] rd_cnt_q;
	logic [AW:0] cmp_idx_q;
	logic cmp_vld_q;
	logic hit_q, have_q, exact_q;
	logic [AW-1:0] best_q;
	logic [RW-1:0] rdata, wdata;
	logic [AW-1:0] waddr, raddr;
	logic [AW-1:0] slot_idx;
	logic we;

	logic r_fam;
	logic [15:0] r_lport, r_pport;
	logic [63:0] r_lhi, r_llo, r_phi, r_plo;
	logic [15:0] key_port;
	logic a_wild, l_wild, base_m, use_m, lk_m, slot_ok;

	assign {r_fam, r_lport, r_lhi, r_llo, r_pport, r_phi, r_plo} = rdata;
	assign slot_idx = AW'(slot_q);
	assign slot_ok = ({5'd0, slot_q} < 9'(SLOTS));
	assign waddr = slot_idx;
	assign raddr = cmd.scan_clr ? '0 : rd_cnt_q[AW-1:0];
	assign we = cmd.commit;
	assign wdata = {fam_q, cmd.use_cand ? cand_q : pa_q, ahi_q, alo_q, pb_q, bhi_q, blo_q};

	udp_pbd_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign key_port = (op_q == OP_BIND && pa_q == 16'd0) ? cand_q : pa_q;
	assign a_wild = (ahi_q == 64'd0) && (alo_q == 64'd0);
	assign l_wild = (r_lhi == 64'd0) && (r_llo == 64'd0);
	assign base_m = cmp_vld_q && valid_q[cmp_idx_q[AW-1:0]] && (r_fam == fam_q)
		&& (r_lport == key_port);
	assign use_m = base_m && (a_wild || l_wild || (r_lhi == ahi_q && r_llo == alo_q));
	assign lk_m = base_m && (l_wild || (r_lhi == ahi_q && r_llo == alo_q))
		&& (r_pport == 16'd0 || (r_pport == pb_q && r_phi == bhi_q && r_plo == blo_q));

	always_comb begin
		sts.op = op_q;
		sts.slot_out = !slot_ok;
		sts.slot_bound = slot_ok && valid_q[slot_idx];
		sts.addr_na = !a_wild && !owned_q;
		sts.port_zero = (pa_q == 16'd0);
		sts.scan_last = !cmd.scan_clr && !cmp_vld_q && (rd_cnt_q == (AW+1)'(SLOTS));
		sts.hit = hit_q;
		sts.cand_zero = (cand_q == 16'd0);
		sts.tries_last = (tries_q == 17'd0);
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= op;
			slot_q <= slot;
			fam_q <= family;
			ahi_q <= addr_a_hi;
			alo_q <= addr_a_lo;
			pa_q <= port_a;
			bhi_q <= addr_b_hi;
			blo_q <= addr_b_lo;
			pb_q <= port_b;
			owned_q <= addr_owned;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= EPH_LOW_RST;
			high_q <= EPH_HIGH_RST;
			next_q <= EPH_FIRST_RST;
			cand_q <= '0;
			tries_q <= '0;
			valid_q <= '0;
			rd_cnt_q <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			hit_q <= 1'b0;
			have_q <= 1'b0;
			exact_q <= 1'b0;
			best_q <= '0;
			res_valid <= 1'b0;
			status <= '0;
			found <= 1'b0;
			match_slot <= '0;
			port <= '0;
		end else begin
			res_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOW: low_q <= cfg_data;
					REG_HIGH: high_q <= cfg_data;
					REG_FIRST: next_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				tries_q <= (high_q >= low_q) ? (17'(high_q) - 17'(low_q) + 17'd1) : 17'd1;
			end
			if (cmd.cand_load) begin
				cand_q <= next_q;
			end
			if (cmd.cand_adv) begin
				next_q <= (cand_q >= high_q) ? low_q : cand_q + 16'd1;
				tries_q <= tries_q - 17'd1;
			end
			if (cmd.scan_clr) begin
				rd_cnt_q <= (AW+1)'(1);
				cmp_idx_q <= '0;
				cmp_vld_q <= 1'b1;
				hit_q <= 1'b0;
				have_q <= 1'b0;
				exact_q <= 1'b0;
				best_q <= '0;
			end else if (cmd.scan_step) begin
				if (use_m) begin
					hit_q <= 1'b1;
				end
				if (lk_m && (!have_q || (!l_wild && !exact_q))) begin
					have_q <= 1'b1;
					exact_q <= !l_wild;
					best_q <= cmp_idx_q[AW-1:0];
				end
				cmp_idx_q <= rd_cnt_q;
				cmp_vld_q <= (rd_cnt_q != (AW+1)'(SLOTS));
				if (rd_cnt_q != (AW+1)'(SLOTS)) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
			end
			if (cmd.commit) begin
				valid_q[slot_idx] <= 1'b1;
			end
			if (cmd.unbind) begin
				valid_q[slot_idx] <= 1'b0;
			end
			if (cmd.done) begin
				res_valid <= 1'b1;
				status <= cmd.status;
				found <= cmd.found && have_q;
				match_slot <= (cmd.found && have_q) ? 4'(best_q) : 4'd0;
				port <= (cmd.found && have_q) ? pa_q
					: (cmd.commit ? (cmd.use_cand ? cand_q : pa_q) : 16'd0);
			end
		end
	end
endmodule

// ===== rtl/udp_pbd_checker.sv =====
module udp_pbd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [1:0] status,
	input logic found,
	input logic [15:0] port
);
	import udp_pbd_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after start");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK) else $error("found with error");
	a_err_port: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> port == 16'd0) else $error("port on error");
endmodule

bind udp_port_bind_and_demux_table udp_pbd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .found(found), .port(port)
);
